@@ rtl/core/hcs_pkg.sv @@
// ----------------------------------------------------------------------------
// hcs_pkg
// Shared constants, types and control structs of the hamiltonian cycle search.
// ----------------------------------------------------------------------------
package hcs_pkg;

  localparam int MAX_VERTICES = 8;
  // vertices usable by the search (edge rows are 8 bits wide)
  localparam int N_LIM        = (MAX_VERTICES < 8) ? MAX_VERTICES : 8;
  localparam int ROW_W        = 8;
  localparam int VTX_W        = 3;
  localparam int CNT_W        = 4;
  localparam int ROW_IDX_W    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int LOAD_W       = $clog2(MAX_VERTICES + 1);
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VERTEX_COUNT   = 1'b0,
    CFG_REQUIRE_RETURN = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_BACK,
    ST_EMIT,
    ST_FAIL
  } state_t;

  typedef struct packed {
    logic row_ready;
    logic advance;
    logic take;
    logic back;
    logic restore;
    logic emit_path;
    logic emit_fail;
  } cmd_t;

  typedef struct packed {
    logic row_valid;
    logic row_last;
    logic cand_any;
    logic last_level;
    logic ret_ok;
    logic level_one;
    logic out_free;
    logic emit_done;
  } stat_t;

endpackage

@@ rtl/core/hcs_row_if.sv @@
// ----------------------------------------------------------------------------
// hcs_row_if
// Adjacency row channel: one row of the graph per item.
// ----------------------------------------------------------------------------
interface hcs_row_if;
  logic                          valid;
  logic                          ready;
  logic [hcs_pkg::ROW_W-1:0]     row_bits;
  logic                          last_row;

  modport source (output valid, output row_bits, output last_row, input ready);
  modport sink   (input valid, input row_bits, input last_row, output ready);
endinterface

@@ rtl/core/hcs_res_if.sv @@
// ----------------------------------------------------------------------------
// hcs_res_if
// Result channel: one path vertex, or one not-found marker, per item.
// ----------------------------------------------------------------------------
interface hcs_res_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [hcs_pkg::VTX_W-1:0]     position;
  logic [hcs_pkg::VTX_W-1:0]     vertex;
  logic                          last;

  modport source (output valid, output found, output position, output vertex,
                  output last, input ready);
  modport sink   (input valid, input found, input position, input vertex,
                  input last, output ready);
endinterface

@@ rtl/core/hcs_cfg_if.sv @@
// ----------------------------------------------------------------------------
// hcs_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface hcs_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [hcs_pkg::CFG_IDX_W-1:0]     index;
  logic [hcs_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/hcs_datapath.sv @@
// ----------------------------------------------------------------------------
// hcs_datapath
// Row store, path stack, visited mask, candidate picker and result register.
// ----------------------------------------------------------------------------
module hcs_datapath (
  input  logic                clk,
  input  logic                rst,
  input  hcs_pkg::cmd_t       cmd,
  output hcs_pkg::stat_t      stat,
  hcs_row_if.sink             row_in,
  hcs_res_if.source           res_out,
  hcs_cfg_if.sink             cfg
);

  logic [hcs_pkg::ROW_W-1:0]      rows [hcs_pkg::MAX_VERTICES];
  logic [hcs_pkg::LOAD_W-1:0]     rows_loaded;
  logic [hcs_pkg::VTX_W-1:0]      stack [hcs_pkg::N_LIM];
  logic [hcs_pkg::N_LIM-1:0]      visited;
  logic [hcs_pkg::VTX_W-1:0]      level;
  logic [hcs_pkg::VTX_W-1:0]      cur_v;
  logic [hcs_pkg::VTX_W-1:0]      prev_v;
  logic [hcs_pkg::CNT_W-1:0]      n_act;
  logic [hcs_pkg::CNT_W-1:0]      vcount;
  logic                           req_ret;
  logic [hcs_pkg::VTX_W-1:0]      emit_idx;

  logic                           out_valid;
  logic                           out_found;
  logic [hcs_pkg::VTX_W-1:0]      out_pos;
  logic [hcs_pkg::VTX_W-1:0]      out_vtx;
  logic                           out_last;

  logic                           row_fire;
  logic                           row_init;
  logic [hcs_pkg::CNT_W-1:0]      n_sat;
  logic [hcs_pkg::ROW_W-1:0]      row_prev;
  logic [hcs_pkg::N_LIM-1:0]      col0;
  logic [hcs_pkg::N_LIM-1:0]      cand;
  logic [hcs_pkg::VTX_W-1:0]      cand_c;
  logic [hcs_pkg::VTX_W-1:0]      rd_addr;
  logic [hcs_pkg::VTX_W-1:0]      stack_rd;
  logic                           out_free;

  assign cfg.ready    = 1'b1;
  assign row_in.ready = cmd.row_ready;
  assign row_fire     = row_in.valid & cmd.row_ready;
  assign row_init     = row_fire & row_in.last_row;

  always_comb begin
    if (vcount < hcs_pkg::CNT_W'(2)) begin
      n_sat = hcs_pkg::CNT_W'(2);
    end else if (vcount > hcs_pkg::CNT_W'(hcs_pkg::N_LIM)) begin
      n_sat = hcs_pkg::CNT_W'(hcs_pkg::N_LIM);
    end else begin
      n_sat = vcount;
    end
  end

  assign row_prev = rows[hcs_pkg::ROW_IDX_W'(prev_v)];

  // candidates above the last one tried, below n, unvisited, adjacent to prev
  always_comb begin
    for (int j = 0; j < hcs_pkg::N_LIM; j++) begin
      col0[j] = rows[j][0];
      cand[j] = (hcs_pkg::CNT_W'(j) > hcs_pkg::CNT_W'(cur_v)) &&
                (hcs_pkg::CNT_W'(j) < n_act) && !visited[j] && row_prev[j];
    end
  end

  always_comb begin
    cand_c = '0;
    for (int j = hcs_pkg::N_LIM - 1; j >= 0; j--) begin
      if (cand[j]) begin
        cand_c = hcs_pkg::VTX_W'(j);
      end
    end
  end

  assign rd_addr  = cmd.emit_path ? emit_idx : level - hcs_pkg::VTX_W'(1);
  assign stack_rd = stack[rd_addr];
  assign out_free = !out_valid || res_out.ready;

  always_comb begin
    stat.row_valid  = row_in.valid;
    stat.row_last   = row_in.last_row;
    stat.cand_any   = |cand;
    stat.last_level = (hcs_pkg::CNT_W'(level) == n_act - hcs_pkg::CNT_W'(1));
    stat.ret_ok     = !req_ret || col0[cand_c];
    stat.level_one  = (level == hcs_pkg::VTX_W'(1));
    stat.out_free   = out_free;
    stat.emit_done  = (hcs_pkg::CNT_W'(emit_idx) == n_act - hcs_pkg::CNT_W'(1));
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_loaded <= '0;
      visited     <= '0;
      level       <= '0;
      vcount      <= hcs_pkg::CNT_W'(5);
      req_ret     <= 1'b1;
      out_valid   <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (hcs_pkg::cfg_reg_t'(cfg.index))
          hcs_pkg::CFG_VERTEX_COUNT:   vcount  <= cfg.data[hcs_pkg::CNT_W-1:0];
          hcs_pkg::CFG_REQUIRE_RETURN: req_ret <= cfg.data[0];
        endcase
      end
      if (row_init) begin
        rows_loaded <= '0;
        visited     <= hcs_pkg::N_LIM'(1);
        level       <= hcs_pkg::VTX_W'(1);
      end else if (row_fire &&
                   rows_loaded < hcs_pkg::LOAD_W'(hcs_pkg::MAX_VERTICES)) begin
        rows_loaded <= rows_loaded + hcs_pkg::LOAD_W'(1);
      end
      if (cmd.advance) begin
        visited[cand_c] <= 1'b1;
        level           <= level + hcs_pkg::VTX_W'(1);
      end
      if (cmd.back) begin
        visited[stack_rd] <= 1'b0;
        level             <= level - hcs_pkg::VTX_W'(1);
      end
      if (cmd.emit_path || cmd.emit_fail) begin
        out_valid <= 1'b1;
      end else if (res_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (row_fire && rows_loaded < hcs_pkg::LOAD_W'(hcs_pkg::MAX_VERTICES)) begin
      rows[rows_loaded[hcs_pkg::ROW_IDX_W-1:0]] <= row_in.row_bits;
    end
    if (row_init) begin
      stack[0] <= '0;
      prev_v   <= '0;
      cur_v    <= '0;
      n_act    <= n_sat;
      emit_idx <= '0;
    end
    if (cmd.advance) begin
      stack[level] <= cand_c;
      prev_v       <= cand_c;
      cur_v        <= '0;
    end
    if (cmd.take) begin
      stack[level] <= cand_c;
    end
    if (cmd.back) begin
      cur_v <= stack_rd;
    end
    if (cmd.restore) begin
      prev_v <= stack_rd;
    end
    if (cmd.emit_path) begin
      out_found <= 1'b1;
      out_pos   <= emit_idx;
      out_vtx   <= stack_rd;
      out_last  <= stat.emit_done;
      emit_idx  <= emit_idx + hcs_pkg::VTX_W'(1);
    end
    if (cmd.emit_fail) begin
      out_found <= 1'b0;
      out_pos   <= '0;
      out_vtx   <= '0;
      out_last  <= 1'b1;
    end
  end

  assign res_out.valid    = out_valid;
  assign res_out.found    = out_found;
  assign res_out.position = out_pos;
  assign res_out.vertex   = out_vtx;
  assign res_out.last     = out_last;

endmodule

@@ rtl/core/hcs_ctrl.sv @@
// ----------------------------------------------------------------------------
// hcs_ctrl
// Sequencer: row loading, search steps, backtracking and result emission.
// ----------------------------------------------------------------------------
module hcs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  hcs_pkg::stat_t      stat,
  output hcs_pkg::cmd_t       cmd
);

  hcs_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hcs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      hcs_pkg::ST_IDLE: begin
        cmd.row_ready = 1'b1;
        if (stat.row_valid && stat.row_last) begin
          state_next = hcs_pkg::ST_SCAN;
        end
      end
      hcs_pkg::ST_SCAN: begin
        priority if (stat.cand_any && !stat.last_level) begin
          cmd.advance = 1'b1;
        end else if (stat.cand_any && stat.ret_ok) begin
          cmd.take   = 1'b1;
          state_next = hcs_pkg::ST_EMIT;
        end else if (stat.level_one) begin
          // nothing left at the first level
          state_next = hcs_pkg::ST_FAIL;
        end else begin
          cmd.back   = 1'b1;
          state_next = hcs_pkg::ST_BACK;
        end
      end
      hcs_pkg::ST_BACK: begin
        // reload the predecessor of the level we fell back to
        cmd.restore = 1'b1;
        state_next  = hcs_pkg::ST_SCAN;
      end
      hcs_pkg::ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_path = 1'b1;
          if (stat.emit_done) begin
            state_next = hcs_pkg::ST_IDLE;
          end
        end
      end
      hcs_pkg::ST_FAIL: begin
        if (stat.out_free) begin
          cmd.emit_fail = 1'b1;
          state_next    = hcs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = hcs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/hamiltonian_cycle_search_core.sv @@
// ----------------------------------------------------------------------------
// hamiltonian_cycle_search_core
// Backtracking search for a hamiltonian cycle (or path) from vertex 0.
// ----------------------------------------------------------------------------
// usage:
//   row_in takes adjacency rows, one item per row, stored in arrival order;
//   the row item with last_row set starts the search.
//   res_out then gives the path, one vertex per item in position order, with
//   last set on the final one, or a single item with found low.
//   cfg writes vertex_count (index 0) and require_return_edge (index 1);
//   write it only while no search is running.
// timing:
//   the search steps forward in ST_SCAN and back through ST_SCAN and ST_BACK,
//   as the path stack has a single read port; the search's length depends on the graph.
//   Results leave at one per cycle while res_out is ready, via an output register.
// reset:
//   clears the row count and the search state; vertex_count returns to 5 and
//   require_return_edge to 1. Stored rows are kept until overwritten.
// stall:
//   a stalled receiver holds the search in emission; no rows are taken until
//   the last result is in the output register.
// ----------------------------------------------------------------------------
module hamiltonian_cycle_search_core (
  input  logic         clk,
  input  logic         rst,
  hcs_cfg_if.sink      cfg,
  hcs_row_if.sink      row_in,
  hcs_res_if.source    res_out
);

  hcs_pkg::cmd_t  cmd;
  hcs_pkg::stat_t stat;

  hcs_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  hcs_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .stat    (stat),
    .row_in  (row_in),
    .res_out (res_out),
    .cfg     (cfg)
  );

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams adjacency rows into the hamiltonian cycle search core under random
// handshake gaps on both channels. Each path vertex or not-found item that
// comes out is compared with a behavioral copy of the search or a fixed result.
// ----------------------------------------------------------------------------
module testbench;

  typedef enum logic {STEP_ROW, STEP_CFG} step_kind_t;
  typedef enum logic [1:0] {CHK_MODEL, CHK_NOT_FOUND, CHK_IDENTITY} chk_t;

  typedef struct packed {
    step_kind_t                     kind;
    logic [hcs_pkg::ROW_W-1:0]      bits;
    logic                           last;
    hcs_pkg::cfg_reg_t              reg_idx;
    logic [hcs_pkg::CFG_DATA_W-1:0] data;
    chk_t                           chk;
    logic [3:0]                     len;
  } dir_step_t;

  typedef struct packed {
    logic                      found;
    logic [hcs_pkg::VTX_W-1:0] position;
    logic [hcs_pkg::VTX_W-1:0] vertex;
    logic                      last;
  } path_item_t;

  localparam int DIR_STEPS   = 33;
  localparam int PHASE_ITEMS = 65;
  localparam int BLOCK_ITEMS = 22;

  logic clk = 1'b0;
  logic rst;

  hcs_cfg_if cfg_ch ();
  hcs_row_if row_ch ();
  hcs_res_if res_ch ();

  hamiltonian_cycle_search_core dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .row_in  (row_ch),
    .res_out (res_ch)
  );

  // shadow of the block: stored rows, row count and both registers
  logic [hcs_pkg::ROW_W-1:0]      model_rows [hcs_pkg::MAX_VERTICES];
  int unsigned                    model_loaded;
  logic [hcs_pkg::CFG_DATA_W-1:0] model_vcount;
  logic                           model_ret;

  path_item_t      path_items [$];
  chk_t            row_chk;
  int unsigned     row_chk_len;
  int unsigned     send_idle_pct;
  int unsigned     recv_idle_pct;
  int unsigned     error_count;
  longint unsigned cycle_count;
  longint unsigned cycle_budget;

  always #1 clk = ~clk;

  function automatic int unsigned active_count(
      input logic [hcs_pkg::CFG_DATA_W-1:0] vc);
    if (vc < 2) return 2;
    if (vc > hcs_pkg::N_LIM) return hcs_pkg::N_LIM;
    return 32'(vc);
  endfunction

  function automatic path_item_t make_item(input logic found, input int unsigned pos,
                                           input int unsigned vtx, input logic last);
    path_item_t it;
    it.found    = found;
    it.position = pos[hcs_pkg::VTX_W-1:0];
    it.vertex   = vtx[hcs_pkg::VTX_W-1:0];
    it.last     = last;
    return it;
  endfunction

  // depth-first search from vertex 0, candidates in ascending order
  function automatic bit find_cycle(
      output logic [hcs_pkg::VTX_W-1:0] trail [hcs_pkg::MAX_VERTICES],
      output int unsigned n, output int unsigned work);
    logic [3:0]  stack [hcs_pkg::MAX_VERTICES];
    logic [7:0]  seen;
    int unsigned k;
    int unsigned c;
    int unsigned i;
    bit          done;
    bit          hit;
    n = active_count(model_vcount);
    for (i = 0; i < hcs_pkg::MAX_VERTICES; i++) stack[i] = '0;
    seen = 8'h01;
    k    = 1;
    work = 0;
    done = 1'b0;
    hit  = 1'b0;
    while (!done) begin
      c = stack[k] + 1;
      work++;
      while (c < n && (seen[c] || !model_rows[stack[k-1]][c])) begin
        c++;
        work++;
      end
      if (c < n && k < n - 1) begin
        stack[k] = c[3:0];
        seen[c]  = 1'b1;
        k++;
        stack[k] = '0;
      end else if (c < n && (!model_ret || model_rows[c][0])) begin
        stack[k] = c[3:0];
        hit      = 1'b1;
        done     = 1'b1;
      end else begin
        // dead end: step back, and give up once level 0 is reached
        stack[k] = '0;
        k--;
        if (k == 0) done = 1'b1;
        else seen[stack[k]] = 1'b0;
      end
    end
    for (i = 0; i < hcs_pkg::MAX_VERTICES; i++) trail[i] = stack[i][hcs_pkg::VTX_W-1:0];
    return hit;
  endfunction

  function automatic dir_step_t row_step(input logic [hcs_pkg::ROW_W-1:0] bits,
                                         input logic last, input chk_t chk,
                                         input int unsigned len);
    dir_step_t st;
    st         = '0;
    st.kind    = STEP_ROW;
    st.bits    = bits;
    st.last    = last;
    st.reg_idx = hcs_pkg::CFG_VERTEX_COUNT;
    st.chk     = chk;
    st.len     = len[3:0];
    return st;
  endfunction

  function automatic dir_step_t cfg_step(input hcs_pkg::cfg_reg_t idx,
                                         input logic [hcs_pkg::CFG_DATA_W-1:0] data);
    dir_step_t st;
    st         = '0;
    st.kind    = STEP_CFG;
    st.reg_idx = idx;
    st.data    = data;
    st.chk     = CHK_MODEL;
    return st;
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  task automatic send_row(input logic [hcs_pkg::ROW_W-1:0] bits, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      row_ch.valid <= 1'b0;
      @(negedge clk);
    end
    row_ch.valid    <= 1'b1;
    row_ch.row_bits <= bits;
    row_ch.last_row <= last;
    do @(posedge clk); while (!row_ch.ready);
    @(negedge clk);
  endtask

  task automatic write_reg(input hcs_pkg::cfg_reg_t idx,
                           input logic [hcs_pkg::CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // hold off rows until every pending result item is out, then let the block settle
  task automatic settle();
    row_ch.valid <= 1'b0;
    @(negedge clk);
    while (path_items.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_ch.ready <= !rst && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > cycle_budget) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    path_item_t                got;
    path_item_t                want;
    logic [hcs_pkg::VTX_W-1:0] trail [hcs_pkg::MAX_VERTICES];
    int unsigned               n;
    int unsigned               work;
    int unsigned               i;
    bit                        hit;
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == hcs_pkg::CFG_VERTEX_COUNT) model_vcount = cfg_ch.data;
        else model_ret = cfg_ch.data[0];
      end
      if (row_ch.valid && row_ch.ready) begin
        cycle_budget += 400;
        // rows past the last slot are dropped
        if (model_loaded < hcs_pkg::MAX_VERTICES) begin
          model_rows[model_loaded] = row_ch.row_bits;
          model_loaded++;
        end
        if (row_ch.last_row) begin
          model_loaded = 0;
          hit = find_cycle(trail, n, work);
          cycle_budget += 16 * work + 400 * n;
          if (row_chk == CHK_NOT_FOUND || (row_chk == CHK_MODEL && !hit)) begin
            path_items.push_back(make_item(1'b0, 0, 0, 1'b1));
          end else if (row_chk == CHK_IDENTITY) begin
            for (i = 0; i < row_chk_len; i++)
              path_items.push_back(make_item(1'b1, i, i, i == row_chk_len - 1));
          end else begin
            for (i = 0; i < n; i++)
              path_items.push_back(make_item(1'b1, i, 32'(trail[i]), i == n - 1));
          end
        end
      end
      if (res_ch.valid && res_ch.ready) begin
        got = make_item(res_ch.found, 32'(res_ch.position), 32'(res_ch.vertex),
                        res_ch.last);
        if (path_items.size() == 0) begin
          report_mismatch($sformatf("unexpected item found=%b pos=%0d vtx=%0d last=%b",
                                    got.found, got.position, got.vertex, got.last));
        end else begin
          want = path_items.pop_front();
          if (got !== want)
            report_mismatch($sformatf(
              "got found=%b pos=%0d vtx=%0d last=%b, want found=%b pos=%0d vtx=%0d last=%b",
              got.found, got.position, got.vertex, got.last,
              want.found, want.position, want.vertex, want.last));
        end
      end
    end
  end

  initial begin
    dir_step_t                      steps [DIR_STEPS];
    logic [hcs_pkg::ROW_W-1:0]      adj [hcs_pkg::MAX_VERTICES];
    logic [hcs_pkg::ROW_W-1:0]      bits;
    logic [hcs_pkg::ROW_W-1:0]      junk_mask;
    logic [hcs_pkg::CFG_DATA_W-1:0] vc;
    int unsigned                    s;
    int unsigned                    phase;
    int unsigned                    items;
    int unsigned                    block_items;
    int unsigned                    n_eff;
    int unsigned                    dens;
    int unsigned                    rows_to_send;
    int unsigned                    sel;
    int unsigned                    r;
    int unsigned                    i;
    int unsigned                    j;
    bit                             broken;

    rst             = 1'b1;
    row_ch.valid    = 1'b0;
    row_ch.row_bits = '0;
    row_ch.last_row = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = hcs_pkg::CFG_VERTEX_COUNT;
    cfg_ch.data     = '0;
    model_loaded    = 0;
    model_vcount    = 4'd5;
    model_ret       = 1'b1;
    row_chk         = CHK_MODEL;
    row_chk_len     = 0;
    error_count     = 0;
    cycle_count     = 0;
    cycle_budget    = 20000;
    send_idle_pct   = 18;
    recv_idle_pct   = 74;

    steps = '{
      // five-ring at reset settings, junk above the vertex count
      row_step(8'hF2, 1'b0, CHK_MODEL, 0), row_step(8'h05, 1'b0, CHK_MODEL, 0),
      row_step(8'hEA, 1'b0, CHK_MODEL, 0), row_step(8'h14, 1'b0, CHK_MODEL, 0),
      row_step(8'h09, 1'b1, CHK_IDENTITY, 5),
      // full graph, ten rows: the two empty ones past the store must be dropped
      row_step(8'hFF, 1'b0, CHK_MODEL, 0), row_step(8'hFF, 1'b0, CHK_MODEL, 0),
      row_step(8'hFF, 1'b0, CHK_MODEL, 0), row_step(8'hFF, 1'b0, CHK_MODEL, 0),
      row_step(8'hFF, 1'b0, CHK_MODEL, 0), row_step(8'hFF, 1'b0, CHK_MODEL, 0),
      row_step(8'hFF, 1'b0, CHK_MODEL, 0), row_step(8'hFF, 1'b0, CHK_MODEL, 0),
      row_step(8'h00, 1'b0, CHK_MODEL, 0), row_step(8'h00, 1'b1, CHK_IDENTITY, 5),
      // count below range saturates to two, vertex 0 isolated
      cfg_step(hcs_pkg::CFG_VERTEX_COUNT, 4'd0),
      cfg_step(hcs_pkg::CFG_REQUIRE_RETURN, 4'd0),
      row_step(8'h00, 1'b1, CHK_NOT_FOUND, 0),
      // count above range saturates to eight, old rows reused
      cfg_step(hcs_pkg::CFG_VERTEX_COUNT, 4'd15),
      cfg_step(hcs_pkg::CFG_REQUIRE_RETURN, 4'd1),
      row_step(8'hFF, 1'b1, CHK_IDENTITY, 8),
      // search backs up to the first level and gives up
      row_step(8'h02, 1'b0, CHK_MODEL, 0), row_step(8'h01, 1'b1, CHK_NOT_FOUND, 0),
      cfg_step(hcs_pkg::CFG_VERTEX_COUNT, 4'd2),
      row_step(8'h02, 1'b0, CHK_MODEL, 0), row_step(8'h01, 1'b1, CHK_IDENTITY, 2),
      // open path accepted only without the closing edge
      cfg_step(hcs_pkg::CFG_VERTEX_COUNT, 4'd3),
      cfg_step(hcs_pkg::CFG_REQUIRE_RETURN, 4'd0),
      row_step(8'h02, 1'b0, CHK_MODEL, 0), row_step(8'h05, 1'b0, CHK_MODEL, 0),
      row_step(8'h02, 1'b1, CHK_IDENTITY, 3),
      cfg_step(hcs_pkg::CFG_REQUIRE_RETURN, 4'd1),
      row_step(8'h02, 1'b1, CHK_NOT_FOUND, 0)
    };

    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (s = 0; s < DIR_STEPS; s++) begin
      if (steps[s].kind == STEP_CFG) begin
        settle();
        write_reg(steps[s].reg_idx, steps[s].data);
      end else begin
        row_chk     = steps[s].chk;
        row_chk_len = steps[s].len;
        send_row(steps[s].bits, steps[s].last);
      end
    end
    row_chk = CHK_MODEL;

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 18;
          recv_idle_pct = 74;
        end
        1: begin
          send_idle_pct = 74;
          recv_idle_pct = 18;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      items = 0;
      while (items < PHASE_ITEMS) begin
        settle();
        // mostly small graphs, a few full-size and out-of-range counts
        sel = $urandom_range(99);
        if (sel < 70) vc = hcs_pkg::CFG_DATA_W'($urandom_range(6, 3));
        else if (sel < 80) vc = hcs_pkg::CFG_DATA_W'($urandom_range(8, 7));
        else if (sel < 90) vc = hcs_pkg::CFG_DATA_W'($urandom_range(2, 0));
        else vc = hcs_pkg::CFG_DATA_W'($urandom_range(15, 9));
        write_reg(hcs_pkg::CFG_VERTEX_COUNT, vc);
        write_reg(hcs_pkg::CFG_REQUIRE_RETURN, hcs_pkg::CFG_DATA_W'($urandom_range(1)));
        n_eff = active_count(vc);
        junk_mask = 8'hFF << n_eff;
        block_items = 0;
        while (block_items < BLOCK_ITEMS) begin
          dens = $urandom_range(100, 30);
          for (i = 0; i < hcs_pkg::MAX_VERTICES; i++) adj[i] = '0;
          for (i = 0; i < n_eff; i++)
            for (j = i + 1; j < n_eff; j++)
              if ($urandom_range(99) < dens) begin
                adj[i][j] = 1'b1;
                adj[j][i] = 1'b1;
              end
          sel = $urandom_range(99);
          if (sel < 80) rows_to_send = n_eff;
          else if (sel < 90) rows_to_send = $urandom_range(n_eff - 1, 1);
          else rows_to_send = $urandom_range(10, n_eff + 1);
          broken = ($urandom_range(99) < 5);
          for (r = 0; r < rows_to_send; r++) begin
            bits = (r < n_eff) ? adj[r] : hcs_pkg::ROW_W'($urandom);
            bits = bits | (hcs_pkg::ROW_W'($urandom) & junk_mask);
            if ($urandom_range(99) < 8) bits = bits ^ (8'h01 << $urandom_range(7));
            send_row(bits, (r == rows_to_send - 1) && !broken);
            items++;
            block_items++;
          end
        end
      end
    end

    settle();
    repeat (20) @(negedge clk);
    if (path_items.size() != 0)
      report_mismatch($sformatf("%0d result items never arrived", path_items.size()));
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/hcs_pkg.sv
rtl/core/hcs_row_if.sv
rtl/core/hcs_res_if.sv
rtl/core/hcs_cfg_if.sv
rtl/core/hcs_datapath.sv
rtl/core/hcs_ctrl.sv
rtl/core/hamiltonian_cycle_search_core.sv
tb/testbench.sv
